### hw/rtl/pca_pkg.sv
// ---------------------------------------------------------------------------
// pca_pkg: shared types and constants for the PID controller
// Beat payloads, configuration register indexes and fixed datapath widths.
// ---------------------------------------------------------------------------
`default_nettype none

package pca_pkg;

    // Sample and gain widths fixed by the field definitions.
    localparam int SAMPLE_WIDTH = 16;
    localparam int GAIN_WIDTH   = 32;
    localparam int DIFF_WIDTH   = SAMPLE_WIDTH + 1;
    // Zero-extended unsigned gain times signed difference, exact.
    localparam int PROD_W       = GAIN_WIDTH + 1 + DIFF_WIDTH;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_ACTING = 3'd5;

    // Reset values of the output limits.
    localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN_RESET = -16'sd255;
    localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX_RESET = 16'sd255;

    // Input beat.
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] measurement;
        logic signed [SAMPLE_WIDTH-1:0] target;
        logic                           auto_mode;
        logic signed [SAMPLE_WIDTH-1:0] manual_value;
    } t_in;

    // Output beat.
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] drive;
        logic                           computed;
    } t_out;

    // Configuration register file contents.
    typedef struct packed {
        logic [GAIN_WIDTH-1:0]          prop_gain;
        logic [GAIN_WIDTH-1:0]          integral_gain;
        logic [GAIN_WIDTH-1:0]          deriv_gain;
        logic signed [SAMPLE_WIDTH-1:0] out_min;
        logic signed [SAMPLE_WIDTH-1:0] out_max;
        logic                           reverse_acting;
    } t_cfg;

    // Input register contents: the beat plus what the mode tracking adds.
    typedef struct packed {
        t_in                          item;
        logic                         enter;
        logic signed [DIFF_WIDTH-1:0] dmeas;
    } t_stage;

    // Product register contents.
    typedef struct packed {
        logic signed [PROD_W-1:0]       pterm;
        logic signed [PROD_W-1:0]       iinc;
        logic signed [PROD_W-1:0]       dterm;
        logic                           enter;
        logic                           auto_mode;
        logic signed [SAMPLE_WIDTH-1:0] manual_value;
    } t_prod;

endpackage

`default_nettype wire

### hw/rtl/pid_controller_antiwindup.sv
// ---------------------------------------------------------------------------
// pid_controller_antiwindup: PID controller, derivative on measurement
// Anti-windup integral, bumpless manual to automatic transfer.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel takes one sample tick per beat: measurement, target,
//   auto_mode and manual_value. Each input beat yields exactly one output
//   beat carrying drive and computed (1 in automatic mode, 0 in manual).
//   The configuration channel writes gains, limits and the reverse flag by
//   index; it is always ready and should be used only while the block is
//   idle. Writing a limit while in automatic clamps the integral and held
//   output to the new limits in the following cycle.
//   A beat passes the input register, gain multiply register and result
//   register in that order. Throughput is one beat per cycle while the
//   receiver keeps up; the integrator feedback loop does not hold the flow.
//   When the receiver stalls, the stages fill one by one and input ready
//   drops only once all three hold a beat; nothing is lost or repeated.
//   Reset is synchronous and active low: it empties the pipeline, clears
//   the integral, held output and previous measurement, selects manual
//   mode, zeroes the gains and sets the limits to -255 and 255.
// ---------------------------------------------------------------------------
`default_nettype none

module pid_controller_antiwindup #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  pca_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output pca_pkg::t_out                  o_out_data,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [pca_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [pca_pkg::GAIN_WIDTH-1:0] i_cfg_data
);
    import pca_pkg::*;

    t_cfg                           cfg;
    logic                           lim_wr;
    logic                           r_a_valid;
    t_stage                         r_a;
    logic                           r_running;
    logic signed [SAMPLE_WIDTH-1:0] r_prev_meas;
    logic                           a_ready;
    logic                           b_valid;
    logic                           b_ready;
    t_prod                          b_prod;
    logic                           in_fire;

    // Configuration registers.
    pca_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_lim_wr    (lim_wr)
    );

    assign o_in_ready = !r_a_valid || a_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    // Mode tracking at the input: entry into automatic and the measurement
    // step are known as soon as the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_running   <= 1'b0;
            r_prev_meas <= '0;
        end else begin
            if (o_in_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (in_fire) begin
                r_running <= i_in_data.auto_mode;
                if (i_in_data.auto_mode) begin
                    r_prev_meas <= i_in_data.measurement;
                end
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a.item  <= i_in_data;
            r_a.enter <= i_in_data.auto_mode && !r_running;
            if (i_in_data.auto_mode && r_running) begin
                r_a.dmeas <= DIFF_WIDTH'(i_in_data.measurement) - DIFF_WIDTH'(r_prev_meas);
            end else begin
                r_a.dmeas <= '0;
            end
        end
    end

    // Gain products.
    pca_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_valid),
        .o_ready (a_ready),
        .i_stage (r_a),
        .i_cfg   (cfg),
        .o_valid (b_valid),
        .i_ready (b_ready),
        .o_prod  (b_prod)
    );

    // Integrator and result register.
    pca_integ #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_integ (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (b_valid),
        .o_ready     (b_ready),
        .i_prod      (b_prod),
        .i_cfg       (cfg),
        .i_lim_wr    (lim_wr),
        .i_running   (r_running),
        .o_valid     (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

    // Input ready only drops while the input register holds a beat.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_a_valid)
        else $error("input ready low with empty input register");

    // A beat in the input register holds while the multiply stage stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !a_ready) |=> (r_a_valid && $stable(r_a)))
        else $error("input register changed while stalled");

    // A manual-to-automatic beat is marked as entering automatic.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.auto_mode && !r_running) |=> r_a.enter)
        else $error("mode entry not flagged");

endmodule

`default_nettype wire

### hw/rtl/pca_cfg.sv
// ---------------------------------------------------------------------------
// pca_cfg: configuration register file
// Holds gains, output limits and the reverse flag; flags limit writes.
// ---------------------------------------------------------------------------
`default_nettype none

module pca_cfg (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [pca_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [pca_pkg::GAIN_WIDTH-1:0]       i_cfg_data,
    output pca_pkg::t_cfg                        o_cfg,
    output logic                                 o_lim_wr
);
    import pca_pkg::*;

    t_cfg r_cfg;
    logic r_lim_wr;

    // Writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Register file with the limit-write flag registered alongside, so the
    // state clamp sees the new limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain      <= '0;
            r_cfg.integral_gain  <= '0;
            r_cfg.deriv_gain     <= '0;
            r_cfg.out_min        <= OUT_MIN_RESET;
            r_cfg.out_max        <= OUT_MAX_RESET;
            r_cfg.reverse_acting <= 1'b0;
            r_lim_wr             <= 1'b0;
        end else begin
            r_lim_wr <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PROP_GAIN:      r_cfg.prop_gain     <= i_cfg_data;
                    CFG_INTEGRAL_GAIN:  r_cfg.integral_gain <= i_cfg_data;
                    CFG_DERIV_GAIN:     r_cfg.deriv_gain    <= i_cfg_data;
                    CFG_OUT_MIN: begin
                        r_cfg.out_min <= i_cfg_data[SAMPLE_WIDTH-1:0];
                        r_lim_wr      <= 1'b1;
                    end
                    CFG_OUT_MAX: begin
                        r_cfg.out_max <= i_cfg_data[SAMPLE_WIDTH-1:0];
                        r_lim_wr      <= 1'b1;
                    end
                    CFG_REVERSE_ACTING: r_cfg.reverse_acting <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    assign o_cfg    = r_cfg;
    assign o_lim_wr = r_lim_wr;

endmodule

`default_nettype wire

### hw/rtl/pca_mult.sv
// ---------------------------------------------------------------------------
// pca_mult: gain multiply stage
// Forms error, the three exact gain products and the reverse-acting sign.
// ---------------------------------------------------------------------------
`default_nettype none

module pca_mult (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  pca_pkg::t_stage i_stage,
    input  pca_pkg::t_cfg   i_cfg,
    output logic            o_valid,
    input  wire             i_ready,
    output pca_pkg::t_prod  o_prod
);
    import pca_pkg::*;

    logic                         r_valid;
    t_prod                        r_prod;
    t_prod                        n_prod;
    logic signed [DIFF_WIDTH-1:0] err;
    logic signed [PROD_W-1:0]     p_raw;
    logic signed [PROD_W-1:0]     i_raw;
    logic signed [PROD_W-1:0]     d_raw;
    logic                         fire;

    assign o_ready = !r_valid || i_ready;
    assign fire    = i_valid && o_ready;

    // Error and products; gains are zero-extended to signed.
    always_comb begin
        err   = DIFF_WIDTH'(i_stage.item.target) - DIFF_WIDTH'(i_stage.item.measurement);
        p_raw = $signed({1'b0, i_cfg.prop_gain}) * err;
        i_raw = $signed({1'b0, i_cfg.integral_gain}) * err;
        d_raw = $signed({1'b0, i_cfg.deriv_gain}) * i_stage.dmeas;

        n_prod.pterm        = i_cfg.reverse_acting ? -p_raw : p_raw;
        n_prod.iinc         = i_cfg.reverse_acting ? -i_raw : i_raw;
        n_prod.dterm        = i_cfg.reverse_acting ? -d_raw : d_raw;
        n_prod.enter        = i_stage.enter;
        n_prod.auto_mode    = i_stage.item.auto_mode;
        n_prod.manual_value = i_stage.item.manual_value;
    end

    // Product register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

`default_nettype wire

### hw/rtl/pca_integ.sv
// ---------------------------------------------------------------------------
// pca_integ: integrator, output sum and result register
// Keeps the integral and held output, saturates both and forms the drive.
// ---------------------------------------------------------------------------
`default_nettype none

module pca_integ #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  pca_pkg::t_prod i_prod,
    input  pca_pkg::t_cfg  i_cfg,
    input  wire            i_lim_wr,
    input  wire            i_running,
    output logic           o_valid,
    input  wire            i_out_ready,
    output pca_pkg::t_out  o_out
);
    import pca_pkg::*;

    localparam int IW = SAMPLE_WIDTH + GAIN_FRAC_BITS;
    localparam int SW = PROD_W + 2;
    localparam int RW = SW - GAIN_FRAC_BITS;
    localparam logic signed [SW-1:0] HALF =
        {{(SW - GAIN_FRAC_BITS){1'b0}}, 1'b1, {(GAIN_FRAC_BITS - 1){1'b0}}};

    logic                           r_valid;
    t_out                           r_out;
    logic signed [IW-1:0]           r_integ;
    logic signed [SAMPLE_WIDTH-1:0] r_held;

    logic signed [IW-1:0]           lim_lo_q;
    logic signed [IW-1:0]           lim_hi_q;
    logic signed [SAMPLE_WIDTH-1:0] held_cl;
    logic signed [IW-1:0]           integ_cl;
    logic signed [IW-1:0]           integ_base;
    logic signed [SW-1:0]           integ_wide;
    logic signed [IW-1:0]           integ_new;
    logic signed [SW-1:0]           sum;
    logic signed [SW-1:0]           shifted;
    logic signed [RW-1:0]           rounded;
    logic signed [SAMPLE_WIDTH-1:0] drv;
    logic                           fire;

    assign o_ready = !r_valid || i_out_ready;
    assign fire    = i_valid && o_ready;

    // Integral limits in Q.F.
    assign lim_lo_q = $signed({i_cfg.out_min, {GAIN_FRAC_BITS{1'b0}}});
    assign lim_hi_q = $signed({i_cfg.out_max, {GAIN_FRAC_BITS{1'b0}}});

    // Saturation tests the upper limit first, so crossed limits resolve the
    // same way everywhere.
    always_comb begin
        if (r_held > i_cfg.out_max) begin
            held_cl = i_cfg.out_max;
        end else if (r_held < i_cfg.out_min) begin
            held_cl = i_cfg.out_min;
        end else begin
            held_cl = r_held;
        end

        if (r_integ > lim_hi_q) begin
            integ_cl = lim_hi_q;
        end else if (r_integ < lim_lo_q) begin
            integ_cl = lim_lo_q;
        end else begin
            integ_cl = r_integ;
        end
    end

    // Integral update; on entry to automatic it starts from the held output.
    always_comb begin
        integ_base = i_prod.enter ? $signed({held_cl, {GAIN_FRAC_BITS{1'b0}}}) : r_integ;
        integ_wide = SW'(integ_base) + SW'(i_prod.iinc);
        if (integ_wide > SW'(lim_hi_q)) begin
            integ_new = lim_hi_q;
        end else if (integ_wide < SW'(lim_lo_q)) begin
            integ_new = lim_lo_q;
        end else begin
            integ_new = integ_wide[IW-1:0];
        end
    end

    // Output sum, round half up, saturate.
    always_comb begin
        sum     = SW'(i_prod.pterm) + SW'(integ_new) - SW'(i_prod.dterm) + HALF;
        shifted = sum >>> GAIN_FRAC_BITS;
        rounded = shifted[RW-1:0];
        if (rounded > RW'(i_cfg.out_max)) begin
            drv = i_cfg.out_max;
        end else if (rounded < RW'(i_cfg.out_min)) begin
            drv = i_cfg.out_min;
        end else begin
            drv = rounded[SAMPLE_WIDTH-1:0];
        end
    end

    // Controller state: updated per beat, clamped after a limit write while in automatic.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_held  <= '0;
        end else if (fire) begin
            if (i_prod.auto_mode) begin
                r_integ <= integ_new;
                r_held  <= drv;
            end else begin
                r_held <= i_prod.manual_value;
            end
        end else if (i_lim_wr && i_running) begin
            r_integ <= integ_cl;
            r_held  <= held_cl;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.drive    <= i_prod.auto_mode ? drv : i_prod.manual_value;
            r_out.computed <= i_prod.auto_mode;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

`default_nettype wire

### tb/pid_controller_antiwindup_test.sv
// ---------------------------------------------------------------------------
// pid_controller_antiwindup_test: self-checking bench for the PID controller
// Drives sample ticks in random bursts, stalls the output side on shifting
// patterns, mirrors the controller in a local predictor and compares every
// output beat, field by field, against the predicted drive and mode flag.
// ---------------------------------------------------------------------------
module pid_controller_antiwindup_test;

    import pca_pkg::*;

    // Fraction bits of the gains and the integral, as the block is built.
    localparam int FRAC = 16;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    t_in                  in_data = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    t_out                 o_out_data;
    logic                 o_cfg_ready;

    // Ticks waiting to be driven and drive values waiting to come out.
    t_in  tick_q[$];
    t_out drive_expect_q[$];

    // Mirror of the register file and the controller state.
    t_cfg   cfg_now;
    longint integ_acc;
    longint last_meas;
    longint held_out;
    logic   in_auto;

    int mismatch_count = 0;
    int ticks_in = 0;
    int beats_out = 0;
    int auto_beats = 0;
    int settings_count = 0;
    int gap_left = 0;
    int burst_left = 0;
    int hold_left = 0;
    int holds_done = 0;
    int pat_left = 0;
    logic [31:0] stall_pat = '1;

    pid_controller_antiwindup u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Clock, period 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Upper limit is tested first, so crossed limits resolve to the upper one.
    function automatic longint limit_to(input longint x, input longint lo, input longint hi);
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    // Unsigned gain times a signed difference. The magnitude stays below 2^49,
    // far inside the 64-bit range, so the product is exact.
    function automatic longint gain_times(input logic [31:0] g, input longint v);
        longint gl;
        gl = longint'(g);
        return gl * v;
    endfunction

    // Register write as the controller sees it, including the re-clamp of the
    // integral and held output when a limit moves during automatic control.
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        longint lo, hi;
        case (idx)
            CFG_PROP_GAIN:      cfg_now.prop_gain = val;
            CFG_INTEGRAL_GAIN:  cfg_now.integral_gain = val;
            CFG_DERIV_GAIN:     cfg_now.deriv_gain = val;
            CFG_OUT_MIN:        cfg_now.out_min = val[15:0];
            CFG_OUT_MAX:        cfg_now.out_max = val[15:0];
            CFG_REVERSE_ACTING: cfg_now.reverse_acting = val[0];
            default: ;
        endcase
        lo = longint'(cfg_now.out_min);
        hi = longint'(cfg_now.out_max);
        if ((idx == CFG_OUT_MIN || idx == CFG_OUT_MAX) && in_auto) begin
            held_out = limit_to(held_out, lo, hi);
            integ_acc = limit_to(integ_acc, lo * (64'sd1 <<< FRAC), hi * (64'sd1 <<< FRAC));
        end
    endfunction

    // One sample tick through the controller: returns the expected output beat.
    function automatic t_out predict_tick(input t_in beat);
        longint meas, err, dmeas, pterm, iinc, dterm, lo, hi, sum, drv;
        t_out res;
        meas = longint'(beat.measurement);
        lo = longint'(cfg_now.out_min);
        hi = longint'(cfg_now.out_max);
        if (!beat.auto_mode) begin
            in_auto = 1'b0;
            held_out = longint'(beat.manual_value);
            res.drive = beat.manual_value;
            res.computed = 1'b0;
            return res;
        end
        // Bumpless transfer on entering automatic control.
        if (!in_auto) begin
            integ_acc = limit_to(held_out, lo, hi) * (64'sd1 <<< FRAC);
            last_meas = meas;
            in_auto = 1'b1;
        end
        err = longint'(beat.target) - meas;
        dmeas = meas - last_meas;
        pterm = gain_times(cfg_now.prop_gain, err);
        iinc = gain_times(cfg_now.integral_gain, err);
        dterm = gain_times(cfg_now.deriv_gain, dmeas);
        if (cfg_now.reverse_acting) begin
            pterm = -pterm;
            iinc = -iinc;
            dterm = -dterm;
        end
        integ_acc = limit_to(integ_acc + iinc, lo * (64'sd1 <<< FRAC), hi * (64'sd1 <<< FRAC));
        sum = pterm + integ_acc - dterm;
        // Round to nearest, ties toward plus infinity.
        drv = (sum + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        drv = limit_to(drv, lo, hi);
        held_out = drv;
        last_meas = meas;
        res.drive = drv[15:0];
        res.computed = 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        if (mismatch_count < 40)
            $display("MISMATCH beat %0d: %s is %0d, predicted %0d", beats_out, field, got, want);
        mismatch_count++;
    endtask

    // Input driver: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end else begin
            if (in_valid && o_in_ready) begin
                drive_expect_q.push_back(predict_tick(in_data));
                ticks_in <= ticks_in + 1;
            end
            if (!in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (tick_q.size() != 0) begin
                    in_valid <= 1'b1;
                    in_data <= tick_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-offs so the pipeline fills and input ready drops.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            holds_done <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if ((holds_done == 0 && ticks_in >= 500) ||
                     (holds_done == 1 && ticks_in >= 1200)) begin
            hold_left <= 150;
            holds_done <= holds_done + 1;
        end
    end

    // Output ready follows a rotating pattern that is reloaded now and then.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            pat_left <= 0;
            stall_pat <= '1;
        end else begin
            if (pat_left == 0) begin
                pat_left <= $urandom_range(16, 200);
                case ($urandom_range(0, 3))
                    0: stall_pat <= '1;
                    1: stall_pat <= $urandom;
                    2: stall_pat <= $urandom | $urandom;
                    default: stall_pat <= $urandom & $urandom & $urandom;
                endcase
            end else begin
                pat_left <= pat_left - 1;
                stall_pat <= {stall_pat[0], stall_pat[31:1]};
            end
            out_ready <= (hold_left == 0) && stall_pat[0];
        end
    end

    // Output monitor: every accepted beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (drive_expect_q.size() == 0) begin
                report_mismatch("beat with nothing pending, drive",
                                longint'(o_out_data.drive), 0);
            end else begin
                want = drive_expect_q.pop_front();
                if (o_out_data.drive !== want.drive)
                    report_mismatch("drive", longint'(o_out_data.drive),
                                    longint'(want.drive));
                if (o_out_data.computed !== want.computed)
                    report_mismatch("computed", longint'(o_out_data.computed),
                                    longint'(want.computed));
                if (want.computed)
                    auto_beats++;
            end
            beats_out++;
        end
    end

    task automatic push_tick(input int meas, input int tgt, input logic auto, input int man);
        t_in b;
        b.measurement = 16'(meas);
        b.target = 16'(tgt);
        b.auto_mode = auto;
        b.manual_value = 16'(man);
        tick_q.push_back(b);
    endtask

    // Waits until everything queued has come out and the pipeline is empty.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (tick_q.size() != 0 || in_valid || drive_expect_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0000_ffff);
            2: return $urandom_range(0, 32'h0004_0000);
            default: return $urandom_range(32'h0000_c000, 32'h0001_4000);
        endcase
    endfunction

    // Settings for one random phase; the first ones pin the extremes.
    task automatic set_phase(input int k);
        int lo, hi;
        logic [31:0] gp, gi, gd;
        gp = pick_gain();
        gi = pick_gain();
        gd = pick_gain();
        lo = $urandom_range(0, 4000);
        lo = lo - 3000;
        hi = lo + int'($urandom_range(1, 4000));
        if (k == 0 || k == 2) begin
            gp = '1;
            gi = '1;
            gd = '1;
        end else if (k == 1) begin
            gp = '0;
            gi = '0;
            gd = '0;
        end
        if (k <= 2 || $urandom_range(0, 5) == 0) begin
            lo = -32768;
            hi = 32767;
        end else if (k == 3) begin
            // Crossed or equal limits.
            lo = $urandom_range(0, 300);
            hi = lo - int'($urandom_range(0, 300));
        end else if ($urandom_range(0, 5) == 0) begin
            hi = lo;
        end
        write_reg(CFG_PROP_GAIN, gp);
        write_reg(CFG_INTEGRAL_GAIN, gi);
        write_reg(CFG_DERIV_GAIN, gd);
        write_reg(CFG_OUT_MIN, lo);
        write_reg(CFG_OUT_MAX, hi);
        write_reg(CFG_REVERSE_ACTING, k % 2);
        settings_count++;
    endtask

    // Mostly runs of automatic ticks around a drifting process value, with
    // manual stretches between runs and single-tick mode flips as noise.
    task automatic queue_random_ticks(input int count);
        int run_left, level, sp, v;
        logic want_auto;
        t_in b;
        run_left = 0;
        want_auto = 1'b0;
        level = $urandom_range(0, 2000);
        level = level - 1000;
        sp = level;
        for (int i = 0; i < count; i++) begin
            if (run_left == 0) begin
                want_auto = ($urandom_range(0, 9) != 0);
                run_left = want_auto ? $urandom_range(5, 60) : $urandom_range(1, 6);
            end
            run_left--;
            b.auto_mode = want_auto ^ ($urandom_range(0, 24) == 0);
            v = $urandom_range(0, 40);
            level = level + v - 20;
            if ($urandom_range(0, 15) == 0) begin
                sp = $urandom_range(0, 4000);
                sp = sp - 2000;
            end
            b.measurement = 16'(($urandom_range(0, 5) == 0) ? $urandom : level);
            b.target = 16'(($urandom_range(0, 7) == 0) ? $urandom : sp);
            v = $urandom_range(0, 600);
            b.manual_value = 16'(($urandom_range(0, 1) == 0) ? $urandom : v - 300);
            tick_q.push_back(b);
        end
    endtask

    // Stimulus sequence and end of run.
    initial begin
        cfg_now = '0;
        cfg_now.out_min = OUT_MIN_RESET;
        cfg_now.out_max = OUT_MAX_RESET;
        integ_acc = 0;
        last_meas = 0;
        held_out = 0;
        in_auto = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: zero gains, entry clamps the held manual value.
        push_tick(0, 0, 1'b0, -32768);
        push_tick(10, 300, 1'b1, 0);
        wait_idle();

        write_reg(CFG_PROP_GAIN, 32'h0001_8000);
        write_reg(CFG_INTEGRAL_GAIN, 32'h0000_4000);
        write_reg(CFG_DERIV_GAIN, 32'h0000_2000);
        write_reg(CFG_OUT_MIN, -1000);
        write_reg(CFG_OUT_MAX, 1000);
        write_reg(CFG_REVERSE_ACTING, 0);
        settings_count++;
        push_tick(0, 0, 1'b0, 32767);
        push_tick(0, 100, 1'b1, 0);
        push_tick(32767, -32768, 1'b1, -1);
        push_tick(-32768, 32767, 1'b1, 0);
        push_tick(100, 100, 1'b1, 0);
        push_tick(5, -5, 1'b0, 2000);
        push_tick(5, 7, 1'b1, 0);
        push_tick(-1, -1, 1'b1, -32768);
        push_tick(20, 40, 1'b1, 0);
        wait_idle();

        // Limit moved during automatic control, then crossed limits.
        write_reg(CFG_OUT_MAX, 10);
        push_tick(20, 40, 1'b1, 0);
        push_tick(25, 40, 1'b1, 0);
        wait_idle();
        write_reg(CFG_OUT_MIN, 20);
        push_tick(30, 40, 1'b1, 0);
        push_tick(30, 0, 1'b1, 0);
        wait_idle();

        // Reverse acting, with a drop to manual and back.
        write_reg(CFG_REVERSE_ACTING, 1);
        write_reg(CFG_OUT_MIN, -500);
        write_reg(CFG_OUT_MAX, 500);
        settings_count++;
        push_tick(30, 40, 1'b1, 0);
        push_tick(35, 0, 1'b1, 0);
        push_tick(35, 0, 1'b0, -7);
        push_tick(35, 900, 1'b1, 0);
        wait_idle();

        for (int k = 0; k < 8; k++) begin
            set_phase(k);
            queue_random_ticks(200);
            wait_idle();
        end

        $display("Covered %0d ticks (%0d computed) under %0d register settings,",
                 beats_out, auto_beats, settings_count);
        $display("including %0d long output hold-offs and crossed and extreme limits.",
                 holds_done);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5000000;
        $display("Run timed out with %0d beats still pending", drive_expect_q.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
